[design/scsd_pkg.sv]
// ----------------------------------------------------------------------------
// scsd_pkg
// shared constants and types of the sum-constrained subvoxel draw unit
// ----------------------------------------------------------------------------
package scsd_pkg;

  localparam int MaxSubvoxelsDef = 8;
  localparam int ClassCountDef   = 4;

  localparam int NumClasses = 4;   // fixed register file size
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 32;

  localparam logic [CfgIdxW-1:0] CfgMeanBase   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgSpreadBase = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgSpreadLast = 4'd7;

  localparam logic [15:0] SpreadRst = 16'd256;

  localparam int DivSteps = 64;    // dividend is sigma^2 shifted up by 32
  localparam int QuotW    = 33;    // weight is at most 2^32
  localparam int FracW    = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ACC,
    ST_DIFF,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL1_GO,
    ST_MUL1_WAIT,
    ST_MUL2_GO,
    ST_MUL2_WAIT,
    ST_EMIT
  } scsd_state_e;

endpackage

[design/scsd_div.sv]
// ----------------------------------------------------------------------------
// scsd_div
// restoring divider, one quotient bit per cycle: floor(num * 2^32 / den)
// ----------------------------------------------------------------------------
module scsd_div import scsd_pkg::*; #(
  parameter int DenW = 35
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      num_i,
  input  logic [DenW-1:0]  den_i,
  output logic             done_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int CntW = $clog2(DivSteps);

  logic                act_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DenW-1:0]     rem_q, den_q;
  logic [DivSteps-1:0] dq_q;
  logic [DenW:0]       trial;
  logic                ge;
  logic [DenW:0]       diff;

  assign trial = {rem_q, dq_q[DivSteps-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          act_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      dq_q  <= {num_i, 32'd0};
    end else if (act_q) begin
      rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      dq_q  <= {dq_q[DivSteps-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q[QuotW-1:0];

endmodule

[design/scsd_mul.sv]
// ----------------------------------------------------------------------------
// scsd_mul
// shift-add multiplier, one weight bit per cycle: floor(a * x / 2^32)
// ----------------------------------------------------------------------------
module scsd_mul import scsd_pkg::*; #(
  parameter int XW = 37
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [QuotW-1:0]    a_i,
  input  logic signed [XW-1:0] x_i,
  output logic                done_o,
  output logic signed [XW:0]  p_o
);

  localparam int AccW = QuotW + XW;
  localparam int CntW = $clog2(QuotW);

  logic                   act_q, done_q;
  logic [CntW-1:0]        cnt_q;
  logic [QuotW-1:0]       a_q;
  logic signed [XW-1:0]   x_q;
  logic signed [AccW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QuotW - 1)) begin
          act_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      x_q   <= x_i;
      acc_q <= '0;
    end else if (act_q) begin
      acc_q <= (acc_q <<< 1) + (a_q[QuotW-1] ? AccW'(x_q) : AccW'(0));
      a_q   <= {a_q[QuotW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q[AccW-1:FracW];

endmodule

[design/sum_constrained_subvoxel_draw_unit.sv]
// ----------------------------------------------------------------------------
// sum_constrained_subvoxel_draw_unit
// draws subvoxel values whose sum is fixed by the voxel observation
// ----------------------------------------------------------------------------
// usage
//   requests come in on start/busy: one request per subvoxel, taken at a
//   rising edge with start high and busy low. a request that neither carries
//   last_subvoxel_i nor fills the buffer is only stored and yields nothing.
//   the closing request starts the draw: busy rises and the unit runs
//   through all buffered subvoxels in arrival order.
//   a voxel of n subvoxels keeps busy high through an accumulation pass over
//   its subvoxels, one difference step and then, per subvoxel, the restoring
//   divider for the class weight (64 steps), two passes of the shift-add
//   multiplier (33 steps each) and one emit step. each result shows on
//   result_valid_o for one cycle, the cycle after its emit; run_end_o marks
//   the last one, and busy falls with it.
//   the receiver cannot stall, results are never held back.
//   configuration is a plain write port (index 0..3 class means, 4..7
//   class spreads); indexes above that are ignored. write only when idle.
//   reset clears the sequencer and the buffer fill, and loads means 0 and
//   spreads 1.0
// ----------------------------------------------------------------------------
module sum_constrained_subvoxel_draw_unit import scsd_pkg::*; #(
  parameter int MAX_SUBVOXELS = MaxSubvoxelsDef,
  parameter int CLASS_COUNT   = ClassCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic [24:0]         subvoxel_number_i,
  input  logic [3:0]          class_mask_i,
  input  logic signed [15:0]  normal_deviate_i,
  input  logic signed [31:0]  observed_value_i,
  input  logic                last_subvoxel_i,
  output logic                result_valid_o,
  output logic [23:0]         target_index_o,
  output logic signed [31:0]  sampled_value_o,
  output logic                run_end_o
);

  localparam int IdxW = (MAX_SUBVOXELS > 1) ? $clog2(MAX_SUBVOXELS) : 1;
  localparam int CntW = $clog2(MAX_SUBVOXELS + 1);
  localparam int SW   = 32 + CntW;       // sum of sigma^2
  localparam int MuW  = 32 + CntW;       // sum of means
  localparam int VvW  = 28;              // one scaled deviate
  localparam int SvW  = VvW + CntW;      // sum of scaled deviates
  localparam int DW   = MuW + 1;         // observation minus mean sum
  localparam int YW   = DW + 3;
  localparam logic signed [YW-1:0] YMax = YW'(64'sd2147483647);
  localparam logic signed [YW-1:0] YMin = -YMax - YW'(1);

  // configuration registers
  logic signed [31:0] mean_q   [NumClasses];
  logic [15:0]        spread_q [NumClasses];

  // subvoxel buffer
  logic [23:0]           hidx_q [MAX_SUBVOXELS];
  logic [1:0]            hcls_q [MAX_SUBVOXELS];
  logic signed [15:0]    hdev_q [MAX_SUBVOXELS];
  logic signed [VvW-1:0] vv_q   [MAX_SUBVOXELS];

  scsd_state_e state_q, state_d;
  logic [CntW-1:0]       fill_q, n_q, j_q;
  logic signed [31:0]    obs_q;
  logic [SW-1:0]         s2_q;
  logic signed [MuW-1:0] mu_q;
  logic signed [SvW-1:0] sv_q;
  logic signed [DW-1:0]  diff_q;
  logic [QuotW-1:0]      a_q;
  logic signed [DW:0]    p1_q, p2_q;

  logic                  vld_q, rend_q;
  logic [23:0]           tidx_q;
  logic signed [31:0]    sval_q;

  // class pick of an incoming request: lowest set bit below CLASS_COUNT
  logic [1:0] in_cls;
  always_comb begin
    in_cls = 2'd0;
    for (int b = CLASS_COUNT - 1; b >= 0; b--) begin
      if (class_mask_i[b]) in_cls = 2'(b);
    end
  end

  logic accept, closing;
  assign accept  = start && !busy;
  assign closing = last_subvoxel_i || (fill_q + 1'b1 == CntW'(MAX_SUBVOXELS));

  // current subvoxel operands
  logic [IdxW-1:0]    jx;
  logic [1:0]         cur_cls;
  logic [15:0]        cur_sg;
  logic [31:0]        cur_sq;
  logic signed [32:0] cur_prod;
  logic signed [VvW-1:0] cur_vv;
  logic               last_j;

  assign jx       = j_q[IdxW-1:0];
  assign cur_cls  = hcls_q[jx];
  assign cur_sg   = spread_q[cur_cls];
  assign cur_sq   = cur_sg * cur_sg;
  assign cur_prod = hdev_q[jx] * $signed({1'b0, cur_sg});
  assign cur_vv   = cur_prod[31:4];      // floor of product over 16
  assign last_j   = (j_q == n_q - 1'b1);

  // shared units
  logic             div_go, div_done, mul_go, mul_done;
  logic [QuotW-1:0] quot;
  logic signed [DW-1:0] mul_x;
  logic signed [DW:0]   mul_p;

  assign div_go = (state_q == ST_DIV_GO);
  assign mul_go = (state_q == ST_MUL1_GO) || (state_q == ST_MUL2_GO);
  assign mul_x  = (state_q == ST_MUL1_GO) ? DW'(sv_q) : diff_q;

  scsd_div #(.DenW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (cur_sq),
    .den_i   (s2_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  scsd_mul #(.XW(DW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (a_q),
    .x_i     (mul_x),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // draw of the current subvoxel, saturated
  logic signed [YW-1:0] y_full;
  logic signed [31:0]   y_sat;
  assign y_full = YW'(vv_q[jx]) + YW'(mean_q[cur_cls]) + YW'(p2_q) - YW'(p1_q);
  always_comb begin
    if (y_full > YMax)      y_sat = 32'sh7FFF_FFFF;
    else if (y_full < YMin) y_sat = 32'sh8000_0000;
    else                    y_sat = y_full[31:0];
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:      if (accept && closing) state_d = ST_ACC;
      ST_ACC:       if (last_j) state_d = ST_DIFF;
      ST_DIFF:      state_d = ST_DIV_GO;
      ST_DIV_GO:    state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_d = ST_MUL1_GO;
      ST_MUL1_GO:   state_d = ST_MUL1_WAIT;
      ST_MUL1_WAIT: if (mul_done) state_d = ST_MUL2_GO;
      ST_MUL2_GO:   state_d = ST_MUL2_WAIT;
      ST_MUL2_WAIT: if (mul_done) state_d = ST_EMIT;
      ST_EMIT:      state_d = last_j ? ST_LOAD : ST_DIV_GO;
      default:      state_d = ST_LOAD;
    endcase
  end

  assign busy = (state_q != ST_LOAD);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      j_q     <= '0;
      vld_q   <= 1'b0;
      for (int c = 0; c < NumClasses; c++) begin
        mean_q[c]   <= '0;
        spread_q[c] <= SpreadRst;
      end
    end else begin
      state_q <= state_d;
      vld_q   <= (state_q == ST_EMIT);
      if (cfg_we_i) begin
        if (cfg_idx_i < CfgSpreadBase) begin
          mean_q[2'(cfg_idx_i - CfgMeanBase)] <= cfg_data_i;
        end else if (cfg_idx_i <= CfgSpreadLast) begin
          spread_q[2'(cfg_idx_i - CfgSpreadBase)] <= cfg_data_i[15:0];
        end
      end
      if (accept) begin
        fill_q <= closing ? '0 : fill_q + 1'b1;
        j_q    <= '0;
      end
      case (state_q)
        ST_ACC:  j_q <= last_j ? '0 : j_q + 1'b1;
        ST_EMIT: j_q <= j_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hidx_q[fill_q[IdxW-1:0]] <= 24'(subvoxel_number_i - 25'd1);
      hcls_q[fill_q[IdxW-1:0]] <= in_cls;
      hdev_q[fill_q[IdxW-1:0]] <= normal_deviate_i;
      if (closing) begin
        n_q   <= fill_q + 1'b1;
        obs_q <= observed_value_i;
        s2_q  <= '0;
        mu_q  <= '0;
        sv_q  <= '0;
      end
    end
    case (state_q)
      ST_ACC: begin
        s2_q     <= s2_q + SW'(cur_sq);
        mu_q     <= mu_q + MuW'(mean_q[cur_cls]);
        sv_q     <= sv_q + SvW'(cur_vv);
        vv_q[jx] <= cur_vv;
      end
      ST_DIFF:      diff_q <= DW'(obs_q) - DW'(mu_q);
      ST_DIV_WAIT:  if (div_done) a_q <= (s2_q == '0) ? '0 : quot;
      ST_MUL1_WAIT: if (mul_done) p1_q <= mul_p;
      ST_MUL2_WAIT: if (mul_done) p2_q <= mul_p;
      ST_EMIT: begin
        tidx_q <= hidx_q[jx];
        sval_q <= y_sat;
        rend_q <= last_j;
      end
      default: ;
    endcase
  end

  assign result_valid_o  = vld_q;
  assign target_index_o  = tidx_q;
  assign sampled_value_o = sval_q;
  assign run_end_o       = rend_q;

  // results only come out of a running draw
  a_res_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a running draw");

  // the closing result leaves the unit ready
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && run_end_o |-> !busy)
    else $error("busy after last result");

  // buffer fill stays below capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CntW'(MAX_SUBVOXELS))
    else $error("buffer overfilled");

endmodule
